/* design/cdm_pkg.sv */
// Shared types, codes and helpers for the clock divider/multiplier.
// No dependencies; every other design file refers to it by scoped names.
package cdm_pkg;

	// Word widths on the stream ports
	localparam int unsigned TDATA_W    = 8;
	localparam int unsigned TUSER_W    = 2;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 16;

	// Field widths
	localparam int unsigned DIV_W   = 5;
	localparam int unsigned PULSE_W = 16;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned CNT_W   = 4;

	// Register reset values
	localparam logic signed [DIV_W-1:0] DIV_RESET   = 5'sd1;
	localparam logic [PULSE_W-1:0]      PULSE_RESET = 16'd480;

	// Division settings that are honored; anything else runs 1:1
	localparam logic signed [DIV_W-1:0] DIV_BY_2 = 5'sd2;
	localparam logic signed [DIV_W-1:0] DIV_BY_4 = 5'sd4;
	localparam logic signed [DIV_W-1:0] DIV_BY_8 = 5'sd8;
	localparam logic signed [DIV_W-1:0] MUL_BY_2 = -5'sd2;
	localparam logic signed [DIV_W-1:0] MUL_BY_4 = -5'sd4;
	localparam logic signed [DIV_W-1:0] MUL_BY_8 = -5'sd8;

	// Item kinds
	typedef enum logic [1:0] {
		OP_SAMPLE  = 2'd0,
		OP_EDGE    = 2'd1,
		OP_DISABLE = 2'd2,
		OP_IGNORE  = 2'd3
	} op_t;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLOCK_DIVISION      = 1'd0,
		REG_CLOCK_PULSE_SAMPLES = 1'd1
	} reg_idx_t;

	// Decoded configuration handed to the step logic
	typedef struct packed {
		logic               mult;      // multiply mode
		logic [CNT_W-1:0]   divisor;   // 1, 2, 4 or 8 when dividing
		logic [1:0]         shift;     // log2 of the factor when multiplying
		logic [PULSE_W-1:0] pulse_len; // clock-out pulse length
	} cfg_t;

	// One result word
	typedef struct packed {
		logic external_mode;
		logic clock_out_high;
		logic step_tick;
	} res_t;

	// Map the raw division register onto an effective setting
	function automatic cfg_t decode_div(input logic signed [DIV_W-1:0] d,
		input logic [PULSE_W-1:0] pulse_len);
		cfg_t c;
		c.mult      = 1'b0;
		c.divisor   = 4'd1;
		c.shift     = 2'd1;
		c.pulse_len = pulse_len;
		case (d)
			DIV_BY_2: c.divisor = 4'd2;
			DIV_BY_4: c.divisor = 4'd4;
			DIV_BY_8: c.divisor = 4'd8;
			MUL_BY_2: begin
				c.mult  = 1'b1;
				c.shift = 2'd1;
			end
			MUL_BY_4: begin
				c.mult  = 1'b1;
				c.shift = 2'd2;
			end
			MUL_BY_8: begin
				c.mult  = 1'b1;
				c.shift = 2'd3;
			end
			default: c.divisor = 4'd1;
		endcase
		return c;
	endfunction

endpackage

/* design/cdm_cfg_regs.sv */
// Configuration registers of the clock divider/multiplier and their decode.
// Depends on cdm_pkg.
module cdm_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cdm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cdm_pkg::CFG_DATA_W-1:0] cfg_data,
	output cdm_pkg::cfg_t                  cfg
);

	logic signed [cdm_pkg::DIV_W-1:0] division_q;
	logic [cdm_pkg::PULSE_W-1:0]      pulse_len_q;
	logic                             wr_en;

	assign cfg_ready = 1'b1;
	assign wr_en     = cfg_valid && cfg_ready;

	// Take a register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			division_q  <= cdm_pkg::DIV_RESET;
			pulse_len_q <= cdm_pkg::PULSE_RESET;
		end else if (wr_en) begin
			case (cdm_pkg::reg_idx_t'(cfg_index))
				cdm_pkg::REG_CLOCK_DIVISION:
					division_q <= $signed(cfg_data[cdm_pkg::DIV_W-1:0]);
				cdm_pkg::REG_CLOCK_PULSE_SAMPLES:
					pulse_len_q <= cfg_data[cdm_pkg::PULSE_W-1:0];
				default: ;
			endcase
		end
	end

	// Decode into the effective division setting
	assign cfg = cdm_pkg::decode_div(division_q, pulse_len_q);

endmodule

/* design/cdm_core.sv */
// Step-tick state and next-state logic: one item is applied per accepted word.
// Depends on cdm_pkg.
module cdm_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_en,
	input  cdm_pkg::op_t      op,
	input  logic              metro_pulse,
	input  cdm_pkg::cfg_t     cfg,
	output cdm_pkg::res_t     res
);

	logic                        ext_q, ext_d;
	logic                        pend_q, pend_d;
	logic [cdm_pkg::CNT_W-1:0]   pcnt_q, pcnt_d;
	logic [cdm_pkg::TIME_W-1:0]  time_q, time_d;
	logic [cdm_pkg::TIME_W-1:0]  last_q, last_d;
	logic [cdm_pkg::TIME_W-1:0]  intv_q, intv_d;
	logic [cdm_pkg::TIME_W-1:0]  subc_q, subc_d;
	logic [cdm_pkg::PULSE_W-1:0] timer_q, timer_d;

	logic [cdm_pkg::CNT_W-1:0]   pcnt_inc;
	logic [cdm_pkg::TIME_W-1:0]  sub_len;
	logic [cdm_pkg::TIME_W-1:0]  subc_inc;
	logic [cdm_pkg::PULSE_W-1:0] timer_ld;
	logic                        tick;

	assign pcnt_inc = pcnt_q + 4'd1;
	assign subc_inc = subc_q + 32'd1;

	// Subdivision length: interval over the factor
	always_comb begin
		case (cfg.shift)
			2'd1:    sub_len = intv_q >> 1;
			2'd2:    sub_len = intv_q >> 2;
			2'd3:    sub_len = intv_q >> 3;
			default: sub_len = intv_q;
		endcase
	end

	// Apply one item
	always_comb begin
		ext_d  = ext_q;
		pend_d = pend_q;
		pcnt_d = pcnt_q;
		time_d = time_q;
		last_d = last_q;
		intv_d = intv_q;
		subc_d = subc_q;
		tick   = 1'b0;
		case (op)
			cdm_pkg::OP_SAMPLE: begin
				if (ext_q) begin
					if (pend_q) begin
						tick   = 1'b1;
						pend_d = 1'b0;
					end
					if (cfg.mult && (intv_q != '0)) begin
						subc_d = subc_inc;
						if ((subc_inc >= sub_len) && (subc_inc < intv_q)) begin
							tick   = 1'b1;
							subc_d = subc_inc + sub_len;
						end
					end
				end else if (!cfg.mult && (cfg.divisor > 4'd1)) begin
					if (metro_pulse) begin
						pcnt_d = pcnt_inc;
						if (pcnt_inc >= cfg.divisor) begin
							tick   = 1'b1;
							pcnt_d = '0;
						end
					end
				end else begin
					tick = metro_pulse;
				end
				time_d = time_q + 32'd1;
			end
			cdm_pkg::OP_EDGE: begin
				ext_d = 1'b1;
				if (!cfg.mult) begin
					pcnt_d = pcnt_inc;
					if (pcnt_inc >= cfg.divisor) begin
						pend_d = 1'b1;
						pcnt_d = '0;
					end
				end else begin
					if (last_q != '0) begin
						intv_d = time_q - last_q;
						subc_d = '0;
					end
					last_d = time_q;
					pend_d = 1'b1;
				end
			end
			cdm_pkg::OP_DISABLE: begin
				ext_d  = 1'b0;
				pend_d = 1'b0;
				pcnt_d = '0;
			end
			default: ;
		endcase
	end

	// Clock-out pulse timer: load on a tick, then count down once per sample
	always_comb begin
		timer_d  = timer_q;
		timer_ld = tick ? cfg.pulse_len : timer_q;
		if (op == cdm_pkg::OP_SAMPLE) begin
			timer_d = (timer_ld != '0) ? timer_ld - 16'd1 : '0;
		end
	end

	assign res.step_tick      = tick;
	assign res.clock_out_high = (timer_d != '0);
	assign res.external_mode  = ext_d;

	// Hold state between accepted words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q   <= 1'b0;
			pend_q  <= 1'b0;
			pcnt_q  <= '0;
			time_q  <= '0;
			last_q  <= '0;
			intv_q  <= '0;
			subc_q  <= '0;
			timer_q <= '0;
		end else if (item_en) begin
			ext_q   <= ext_d;
			pend_q  <= pend_d;
			pcnt_q  <= pcnt_d;
			time_q  <= time_d;
			last_q  <= last_d;
			intv_q  <= intv_d;
			subc_q  <= subc_d;
			timer_q <= timer_d;
		end
	end

endmodule

/* design/cdm_out_buf.sv */
// Two-entry result buffer: output register plus a skid stage.
// Depends on cdm_pkg.
module cdm_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  cdm_pkg::res_t in_res,
	output logic          out_valid,
	input  logic          out_ready,
	output cdm_pkg::res_t out_res
);

	logic          out_valid_q;
	logic          skid_valid_q;
	cdm_pkg::res_t out_res_q;
	cdm_pkg::res_t skid_res_q;
	logic          in_fire;
	logic          out_fire;

	assign in_ready  = !skid_valid_q;
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid_q && out_ready;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_fire) begin
				out_valid_q  <= skid_valid_q || in_fire;
				skid_valid_q <= 1'b0;
			end else if (in_fire) begin
				if (out_valid_q) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	// Payload: drain skid first, park a word when the output is stalled
	always_ff @(posedge clk) begin
		if (out_fire) begin
			if (skid_valid_q) begin
				out_res_q <= skid_res_q;
			end else if (in_fire) begin
				out_res_q <= in_res;
			end
		end else if (in_fire) begin
			if (out_valid_q) begin
				skid_res_q <= in_res;
			end else begin
				out_res_q <= in_res;
			end
		end
	end

endmodule

/* design/clock_divider_multiplier.sv */
// Top level of the step-tick generator with clock division and multiplication.
// Depends on cdm_pkg, cdm_cfg_regs, cdm_core and cdm_out_buf.
//
// Takes one word per clock cycle while s_tready is high and returns exactly one
// result word for each, registered in the output buffer. All state is updated
// in a single pass of logic between the input handshake and the result register,
// so back-to-back words run at one per cycle. A two-entry output buffer lets the
// input keep taking words while one result waits; s_tready drops only when both
// entries are full. Configuration writes are taken at any time (cfg_ready is
// always high) and should be made while no words are in flight.
module clock_divider_multiplier (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cdm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cdm_pkg::CFG_DATA_W-1:0] cfg_data,
	// Input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [cdm_pkg::TDATA_W-1:0]    s_tdata,  // [0] metro_pulse, [7:1] zero
	input  logic [cdm_pkg::TUSER_W-1:0]    s_tuser,  // [1:0] operation
	// Result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [cdm_pkg::TDATA_W-1:0]    m_tdata   // [0] step_tick, [1] clock_out_high,
	                                                 // [2] external_mode, [7:3] zero
);

	cdm_pkg::cfg_t cfg;
	cdm_pkg::res_t core_res;
	cdm_pkg::res_t out_res;
	logic          item_en;

	assign item_en = s_tvalid && s_tready;

	cdm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cdm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_en     (item_en),
		.op          (cdm_pkg::op_t'(s_tuser)),
		.metro_pulse (s_tdata[0]),
		.cfg         (cfg),
		.res         (core_res)
	);

	cdm_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_res    (core_res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	// Pack the result word
	assign m_tdata = {5'd0, out_res.external_mode, out_res.clock_out_high, out_res.step_tick};

endmodule
